FILE: hw/rtl/ustc_pkg.sv
// Shared types, constants and tables for the Unix seconds to calendar converter.
// Depends on nothing; the top level, ustc_calc and the testbench import it.
`default_nettype none

package ustc_pkg;

    // Number of register stages from the input transfer to the output register.
    localparam int NUM_STAGES = 12;

    // Largest supported time: 9999-12-31 23:59:59.
    localparam logic [37:0] MAX_SECONDS = 38'd253402300799;

    // Days from 0000-03-01 to 1970-01-01 in the March-based civil count.
    localparam logic [21:0] EPOCH_SHIFT = 22'd719468;
    localparam logic [22:0] DAYS_PER_ERA = 23'd146097;
    localparam logic [17:0] LAST_DAY_OF_ERA = 18'd146096;

    // Ceiling reciprocals: floor(x / d) == (x * RECIP) >> SHIFT for every x
    // below 2**n, with SHIFT = n + ceil(log2(d)).
    localparam logic [31:0] DAY_RECIP  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
    localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
    localparam logic [22:0] ERA_RECIP  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam logic [18:0] D1460_RECIP  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] D36524_RECIP = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] D365_RECIP = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  D100_RECIP = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] D153_RECIP = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [22:0] WK_RECIP   = 23'(((64'd1 << 25) + 64'd6) / 64'd7);

    typedef logic [NUM_STAGES-1:0] stage_mask_t;

    typedef struct packed {
        logic [37:0] unix_seconds;
        logic        use_local;
    } stamp_t;

    typedef struct packed {
        logic signed [4:0] utc_offset_hours;
    } cfg_t;

    typedef struct packed {
        logic [12:0] years_since_1900;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [8:0]  day_of_year;
        logic [2:0]  weekday_index;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
        logic        out_of_range;
    } cal_t;

    // First day of each March-based month, (153 * mp + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ustc_stream_if.sv
// Valid/ready channel carrying one payload of a chosen type.
// Stands alone; the payload types come from ustc_pkg at the point of use.
`default_nettype none

interface ustc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/unix_seconds_to_calendar_top.sv
// Pipeline: twelve register stages, from the input stage to the output register.
// Throughput: one timestamp per cycle while the output is taken; every divide is
// a reciprocal multiply with a remainder step, so nothing iterates.
// Stalls: each stage loads while it or any later stage is empty or the output
// is taken, so bubbles close up and the output register holds under backpressure.
// Reset: all stage valid bits and the hour offset clear; no memory to sweep.
// Top level of the Unix seconds to calendar converter.
// Depends on ustc_pkg, ustc_stream_if and ustc_calc.
`default_nettype none

module unix_seconds_to_calendar_top import ustc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    ustc_stream_if.sink   stamp,
    ustc_stream_if.source calendar,
    ustc_stream_if.sink   cfg
);

    localparam logic [3:0] MONTH_JANUARY = 4'd0;

    // Offset in seconds, kept pre-multiplied so the input stage only adds.
    logic signed [16:0] off_sec_reg, off_sec_next;

    stage_mask_t vld_reg, vld_next;
    stage_mask_t load;

    logic [37:0] ut_reg, ut_next;
    logic        oor_reg, oor_next;

    logic in_xfer;
    logic out_xfer;

    // ------------------------------------------------------------------
    // Configuration: take every write; the offset is only read by the input stage.
    // Writes must come only while the pipeline is idle; the block does not check.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        logic signed [17:0] scaled;
        scaled = 18'($signed(cfg.payload.utc_offset_hours)) * $signed(18'sd3600);
        off_sec_next = off_sec_reg;
        if (cfg.valid)
        begin
            off_sec_next = scaled[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_sec_reg <= '0;
        end
        else
        begin
            off_sec_reg <= off_sec_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it or any stage after it is empty,
    // or when the output transfer completes this cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            load[i] = calendar.ready || (((~vld_reg) >> i) != '0);
        end
    end

    always_comb
    begin
        vld_next[0] = load[0] ? stamp.valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = load[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign stamp.ready = load[0];
    assign in_xfer     = stamp.valid & stamp.ready;

    // ------------------------------------------------------------------
    // Stage one: apply the offset, then clamp below zero and saturate
    // above the last second of year 9999. A raw input above the bound
    // flags the result even if the offset pulls it back in range.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [39:0] t_sum;
        logic [39:0]        add;
        logic               neg;
        logic               over;
        add   = stamp.payload.use_local ? {{23{off_sec_reg[16]}}, off_sec_reg} : '0;
        t_sum = $signed({2'b00, stamp.payload.unix_seconds}) + $signed(add);
        neg   = t_sum[39];
        over  = !neg && (t_sum[38:0] > {1'b0, MAX_SECONDS});
        if (neg)
        begin
            ut_next = '0;
        end
        else if (over)
        begin
            ut_next = MAX_SECONDS;
        end
        else
        begin
            ut_next = t_sum[37:0];
        end
        oor_next = neg || over || (stamp.payload.unix_seconds > MAX_SECONDS);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            ut_reg  <= ut_next;
            oor_reg <= oor_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages two to twelve: day split, civil date, time of day.
    // ------------------------------------------------------------------
    ustc_calc u_calc (
        .clk    (clk),
        .load   (load),
        .ut     (ut_reg),
        .oor    (oor_reg),
        .result (calendar.payload)
    );

    assign calendar.valid = vld_reg[NUM_STAGES-1];
    assign out_xfer       = calendar.valid & calendar.ready;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NUM_STAGES-1] |-> stamp.ready)
        else $error("input stalled with an empty output stage");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (int'($countones(vld_reg)) ==
            int'($past($countones(vld_reg))) + int'($past(in_xfer))
            - int'($past(out_xfer))))
        else $error("items lost or duplicated in the pipeline");

    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        calendar.valid |-> (calendar.payload.years_since_1900 >= 13'd70)
            && (calendar.payload.month_index <= 4'd11)
            && (calendar.payload.day_of_month >= 5'd1)
            && (calendar.payload.weekday_index <= 3'd6)
            && (calendar.payload.hour_of_day <= 5'd23)
            && (calendar.payload.minute_of_hour <= 6'd59)
            && (calendar.payload.second_of_minute <= 6'd59))
        else $error("calendar field out of range");

    a_january_yday: assert property (@(posedge clk) disable iff (!rst_n)
        calendar.valid && (calendar.payload.month_index == MONTH_JANUARY)
            |-> (calendar.payload.day_of_year
                 == {4'd0, calendar.payload.day_of_month} - 9'd1))
        else $error("day of year disagrees with January date");

endmodule

`default_nettype wire

FILE: hw/rtl/ustc_calc.sv
// Calendar datapath: stages two through twelve of the converter pipeline.
// Depends on ustc_pkg for reciprocals, the month table and the result type.
`default_nettype none

module ustc_calc import ustc_pkg::*;
(
    input  wire logic        clk,
    input  wire stage_mask_t load,
    input  wire logic [37:0] ut,
    input  wire logic        oor,
    output cal_t             result
);

    typedef struct packed {
        logic [21:0] days;
        logic [9:0]  xlo;
        logic [6:0]  lo7;
        logic        oor;
    } st2_t;

    typedef struct packed {
        logic [21:0] z;
        logic [21:0] wk_x;
        logic [16:0] sod;
        logic        oor;
    } st3_t;

    typedef struct packed {
        logic [4:0]  era;
        logic [17:0] z_lo;
        logic [4:0]  hour;
        logic [11:0] sod_lo;
        logic [2:0]  wk_q;
        logic [2:0]  wk_x;
        logic        oor;
    } st4_t;

    typedef struct packed {
        logic [17:0] doe;
        logic [4:0]  era;
        logic [4:0]  hour;
        logic [11:0] rem_h;
        logic [2:0]  wday;
        logic        oor;
    } st5_t;

    typedef struct packed {
        logic [17:0] doe;
        logic [6:0]  a;
        logic [2:0]  b;
        logic        c;
        logic [4:0]  era;
        logic [4:0]  hour;
        logic [11:0] rem_h;
        logic [5:0]  mins;
        logic [2:0]  wday;
        logic        oor;
    } st6_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] mins;
        logic [5:0] secs;
    } tod_t;

    typedef struct packed {
        logic [17:0] v;
        logic [17:0] doe;
        logic [4:0]  era;
        tod_t        tod;
        logic [2:0]  wday;
        logic        oor;
    } st7_t;

    typedef struct packed {
        logic [8:0]  yoe;
        logic [17:0] doe;
        logic [4:0]  era;
        tod_t        tod;
        logic [2:0]  wday;
        logic        oor;
    } st8_t;

    typedef struct packed {
        logic [8:0]  yoe;
        logic [1:0]  yc;
        logic [13:0] ybase;
        logic [17:0] doe;
        tod_t        tod;
        logic [2:0]  wday;
        logic        oor;
    } st9_t;

    typedef struct packed {
        logic [8:0]  doy;
        logic        leap;
        logic [13:0] ybase;
        tod_t        tod;
        logic [2:0]  wday;
        logic        oor;
    } st10_t;

    typedef struct packed {
        logic [3:0]  mp;
        logic [8:0]  doy;
        logic        leap;
        logic [13:0] ybase;
        tod_t        tod;
        logic [2:0]  wday;
        logic        oor;
    } st11_t;

    st2_t  st2_reg,  st2_next;
    st3_t  st3_reg,  st3_next;
    st4_t  st4_reg,  st4_next;
    st5_t  st5_reg,  st5_next;
    st6_t  st6_reg,  st6_next;
    st7_t  st7_reg,  st7_next;
    st8_t  st8_reg,  st8_next;
    st9_t  st9_reg,  st9_next;
    st10_t st10_reg, st10_next;
    st11_t st11_reg, st11_next;
    cal_t  out_reg,  out_next;

    // Split seconds into days: (ut / 128) / 675 by reciprocal.
    always_comb
    begin
        logic [62:0] prod;
        prod = 63'(ut[37:7]) * 63'(DAY_RECIP);
        st2_next.days = prod[62:41];
        st2_next.xlo  = ut[16:7];
        st2_next.lo7  = ut[6:0];
        st2_next.oor  = oor;
    end

    // Remainder gives second of day; shift day count to the March-based epoch and by four for the weekday.
    always_comb
    begin
        logic [31:0] back;
        logic [9:0]  rem;
        back = 32'(st2_reg.days) * 32'd675;
        rem  = st2_reg.xlo - back[9:0];
        st3_next.sod  = {rem, st2_reg.lo7};
        st3_next.z    = st2_reg.days + EPOCH_SHIFT;
        st3_next.wk_x = st2_reg.days + 22'd4;
        st3_next.oor  = st2_reg.oor;
    end

    // Era, hour and week quotients.
    always_comb
    begin
        logic [44:0] era_prod;
        logic [34:0] hour_prod;
        logic [44:0] wk_prod;
        era_prod  = 45'(st3_reg.z) * 45'(ERA_RECIP);
        hour_prod = 35'(st3_reg.sod) * 35'(HOUR_RECIP);
        wk_prod   = 45'(st3_reg.wk_x) * 45'(WK_RECIP);
        st4_next.era    = era_prod[44:40];
        st4_next.z_lo   = st3_reg.z[17:0];
        st4_next.hour   = hour_prod[33:29];
        st4_next.sod_lo = st3_reg.sod[11:0];
        st4_next.wk_q   = wk_prod[27:25];
        st4_next.wk_x   = st3_reg.wk_x[2:0];
        st4_next.oor    = st3_reg.oor;
    end

    // Remainders: day of era, second of hour, weekday.
    always_comb
    begin
        logic [22:0] era_back;
        logic [16:0] hour_back;
        logic [5:0]  wk_back;
        era_back  = 23'(st4_reg.era) * DAYS_PER_ERA;
        hour_back = 17'(st4_reg.hour) * 17'd3600;
        wk_back   = 6'(st4_reg.wk_q) * 6'd7;
        st5_next.doe   = st4_reg.z_lo - era_back[17:0];
        st5_next.era   = st4_reg.era;
        st5_next.hour  = st4_reg.hour;
        st5_next.rem_h = st4_reg.sod_lo - hour_back[11:0];
        st5_next.wday  = st4_reg.wk_x - wk_back[2:0];
        st5_next.oor   = st4_reg.oor;
    end

    // Leap corrections inside the era and the minute quotient.
    always_comb
    begin
        logic [36:0] a_prod;
        logic [36:0] b_prod;
        logic [24:0] m_prod;
        a_prod = 37'(st5_reg.doe) * 37'(D1460_RECIP);
        b_prod = 37'(st5_reg.doe) * 37'(D36524_RECIP);
        m_prod = 25'(st5_reg.rem_h) * 25'(MIN_RECIP);
        st6_next.doe   = st5_reg.doe;
        st6_next.a     = a_prod[35:29];
        st6_next.b     = b_prod[36:34];
        st6_next.c     = (st5_reg.doe == LAST_DAY_OF_ERA);
        st6_next.era   = st5_reg.era;
        st6_next.hour  = st5_reg.hour;
        st6_next.rem_h = st5_reg.rem_h;
        st6_next.mins  = m_prod[23:18];
        st6_next.wday  = st5_reg.wday;
        st6_next.oor   = st5_reg.oor;
    end

    always_comb
    begin
        logic [11:0] m_back;
        m_back = 12'(st6_reg.mins) * 12'd60;
        st7_next.v = st6_reg.doe - 18'(st6_reg.a) + 18'(st6_reg.b) - 18'(st6_reg.c);
        st7_next.doe      = st6_reg.doe;
        st7_next.era      = st6_reg.era;
        st7_next.tod.hour = st6_reg.hour;
        st7_next.tod.mins = st6_reg.mins;
        st7_next.tod.secs = st6_reg.rem_h[5:0] - m_back[5:0];
        st7_next.wday     = st6_reg.wday;
        st7_next.oor      = st6_reg.oor;
    end

    // Year of era.
    always_comb
    begin
        logic [36:0] y_prod;
        y_prod = 37'(st7_reg.v) * 37'(D365_RECIP);
        st8_next.yoe  = y_prod[35:27];
        st8_next.doe  = st7_reg.doe;
        st8_next.era  = st7_reg.era;
        st8_next.tod  = st7_reg.tod;
        st8_next.wday = st7_reg.wday;
        st8_next.oor  = st7_reg.oor;
    end

    // Century of era and the March-based year.
    always_comb
    begin
        logic [18:0] c_prod;
        c_prod = 19'(st8_reg.yoe) * 19'(D100_RECIP);
        st9_next.yoe   = st8_reg.yoe;
        st9_next.yc    = c_prod[17:16];
        st9_next.ybase = 14'(st8_reg.era) * 14'd400 + 14'(st8_reg.yoe);
        st9_next.doe   = st8_reg.doe;
        st9_next.tod   = st8_reg.tod;
        st9_next.wday  = st8_reg.wday;
        st9_next.oor   = st8_reg.oor;
    end

    // Day of the March-based year; leap test of the year that holds February.
    always_comb
    begin
        logic [17:0] y365;
        logic [8:0]  c100;
        y365 = 18'(st9_reg.yoe) * 18'd365;
        c100 = 9'(st9_reg.yc) * 9'd100;
        st10_next.doy  = st9_reg.doe[8:0] - y365[8:0] - 9'(st9_reg.yoe[8:2])
                       + 9'(st9_reg.yc);
        st10_next.leap = ((st9_reg.yoe[1:0] == 2'd0) && (st9_reg.yoe != c100))
                       || (st9_reg.yoe == 9'd0);
        st10_next.ybase = st9_reg.ybase;
        st10_next.tod   = st9_reg.tod;
        st10_next.wday  = st9_reg.wday;
        st10_next.oor   = st9_reg.oor;
    end

    // March-based month.
    always_comb
    begin
        logic [10:0] num;
        logic [22:0] mp_prod;
        num     = 11'(st10_reg.doy) * 11'd5 + 11'd2;
        mp_prod = 23'(num) * 23'(D153_RECIP);
        st11_next.mp    = mp_prod[22:19];
        st11_next.doy   = st10_reg.doy;
        st11_next.leap  = st10_reg.leap;
        st11_next.ybase = st10_reg.ybase;
        st11_next.tod   = st10_reg.tod;
        st11_next.wday  = st10_reg.wday;
        st11_next.oor   = st10_reg.oor;
    end

    // Back to January-based fields; January and February belong to the next year.
    always_comb
    begin
        logic        early;
        logic [8:0]  dom;
        logic [13:0] year;
        logic [13:0] rel;
        early = (st11_reg.mp >= 4'd10);
        dom   = st11_reg.doy - month_start(st11_reg.mp) + 9'd1;
        year  = st11_reg.ybase + 14'(early);
        rel   = year - 14'd1900;
        out_next.years_since_1900 = rel[12:0];
        out_next.month_index = early ? (st11_reg.mp - 4'd10) : (st11_reg.mp + 4'd2);
        out_next.day_of_month = dom[4:0];
        out_next.day_of_year  = early ? (st11_reg.doy - 9'd306)
                                      : (st11_reg.doy + 9'd59 + 9'(st11_reg.leap));
        out_next.weekday_index    = st11_reg.wday;
        out_next.hour_of_day      = st11_reg.tod.hour;
        out_next.minute_of_hour   = st11_reg.tod.mins;
        out_next.second_of_minute = st11_reg.tod.secs;
        out_next.out_of_range     = st11_reg.oor;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])  st2_reg  <= st2_next;
        if (load[2])  st3_reg  <= st3_next;
        if (load[3])  st4_reg  <= st4_next;
        if (load[4])  st5_reg  <= st5_next;
        if (load[5])  st6_reg  <= st6_next;
        if (load[6])  st7_reg  <= st7_next;
        if (load[7])  st8_reg  <= st8_next;
        if (load[8])  st9_reg  <= st9_next;
        if (load[9])  st10_reg <= st10_next;
        if (load[10]) st11_reg <= st11_next;
        if (load[11]) out_reg  <= out_next;
    end

    assign result = out_reg;

endmodule

`default_nettype wire

FILE: tb/tb_unix_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for unix_seconds_to_calendar_top: directed table, then random phases.
// Depends on ustc_pkg, ustc_stream_if and the converter RTL; needs no files or arguments.

module tb_unix_seconds_to_calendar_top;
    import ustc_pkg::*;

    // Calendar arithmetic constants for the expected-value model.
    localparam longint SECS_PER_DAY  = 86400;
    localparam longint SECS_PER_HOUR = 3600;
    localparam longint SECS_PER_MIN  = 60;
    localparam longint ERA_DAYS      = 146097;
    localparam longint MARCH_EPOCH   = 719468;

    // A receiver hold-off of this many cycles is long enough to fill every stage.
    localparam int HOLD_OFF_CYCLES = 300;
    // Quiet-cycle limit: the hold-off plus drain waits and the longest random gaps,
    // taken several times over.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Let the pipeline settle this long before a register write and at the end.
    localparam int SETTLE_CYCLES   = NUM_STAGES + 4;
    localparam int RANDOM_PHASES   = 6;
    localparam int STAMPS_PER_PHASE = 105;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [37:0] ALL_ONES = {38{1'b1}};

    // Results that can be read off the calendar by eye.
    localparam cal_t EPOCH_CAL =
        '{13'd70, 4'd0, 5'd1, 9'd0, 3'd4, 5'd0, 6'd0, 6'd0, 1'b0};
    localparam cal_t EPOCH_CLAMPED =
        '{13'd70, 4'd0, 5'd1, 9'd0, 3'd4, 5'd0, 6'd0, 6'd0, 1'b1};
    localparam cal_t FIRST_DAY_END =
        '{13'd70, 4'd0, 5'd1, 9'd0, 3'd4, 5'd23, 6'd59, 6'd59, 1'b0};
    localparam cal_t LAST_CAL =
        '{13'd8099, 4'd11, 5'd31, 9'd364, 3'd5, 5'd23, 6'd59, 6'd59, 1'b0};
    localparam cal_t LAST_SATURATED =
        '{13'd8099, 4'd11, 5'd31, 9'd364, 3'd5, 5'd23, 6'd59, 6'd59, 1'b1};

    typedef enum logic { ROW_STAMP, ROW_OFFSET } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        int          hours;      // offset to write, ROW_OFFSET only
        logic [37:0] seconds;
        logic        use_local;
        bit          pinned;     // expected result typed in below
        cal_t        want;
    } row_t;

    // Directed stimulus: bounds, clamping, saturation, leap days and offset carries.
    row_t script [25] = '{
        '{ROW_STAMP,    0, 38'd0,                     1'b0, 1'b1, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd0,                     1'b1, 1'b1, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd86399,                 1'b0, 1'b1, FIRST_DAY_END},
        '{ROW_STAMP,    0, MAX_SECONDS,               1'b0, 1'b1, LAST_CAL},
        '{ROW_STAMP,    0, MAX_SECONDS + 38'd1,       1'b0, 1'b1, LAST_SATURATED},
        '{ROW_STAMP,    0, ALL_ONES,                  1'b0, 1'b1, LAST_SATURATED},
        '{ROW_STAMP,    0, 38'd951782400,             1'b0, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd978307199,             1'b0, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd4107542399,            1'b0, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd4107542400,            1'b0, 1'b0, EPOCH_CAL},
        '{ROW_OFFSET, -16, 38'd0,                     1'b0, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd0,                     1'b1, 1'b1, EPOCH_CLAMPED},
        '{ROW_STAMP,    0, 38'd57599,                 1'b1, 1'b1, EPOCH_CLAMPED},
        '{ROW_STAMP,    0, 38'd57600,                 1'b1, 1'b1, EPOCH_CAL},
        '{ROW_STAMP,    0, MAX_SECONDS + 38'd1,       1'b1, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, ALL_ONES,                  1'b1, 1'b1, LAST_SATURATED},
        '{ROW_STAMP,    0, 38'd951782400,             1'b0, 1'b0, EPOCH_CAL},
        '{ROW_OFFSET,  15, 38'd0,                     1'b0, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, MAX_SECONDS,               1'b1, 1'b1, LAST_SATURATED},
        '{ROW_STAMP,    0, MAX_SECONDS - 38'd54000,   1'b1, 1'b1, LAST_CAL},
        '{ROW_STAMP,    0, 38'd978307199,             1'b1, 1'b0, EPOCH_CAL},
        '{ROW_OFFSET, -12, 38'd0,                     1'b0, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd951782400,             1'b1, 1'b0, EPOCH_CAL},
        '{ROW_OFFSET,  14, 38'd0,                     1'b0, 1'b0, EPOCH_CAL},
        '{ROW_STAMP,    0, 38'd86399,                 1'b1, 1'b0, EPOCH_CAL}
    };

    string field_name [9] = '{"years_since_1900", "month_index", "day_of_month",
                              "day_of_year", "weekday_index", "hour_of_day",
                              "minute_of_hour", "second_of_minute", "out_of_range"};

    logic clk = 1'b0;
    logic rst_n;

    ustc_stream_if #(.payload_t(stamp_t)) stamp_if ();
    ustc_stream_if #(.payload_t(cal_t))   calendar_if ();
    ustc_stream_if #(.payload_t(cfg_t))   cfg_if ();

    unix_seconds_to_calendar_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .stamp    (stamp_if),
        .calendar (calendar_if),
        .cfg      (cfg_if)
    );

    // Model state: our copy of the offset register and the results still owed.
    logic signed [4:0] offset_model = 5'sd0;
    cal_t              calendar_due [$];

    // Typed-in expectation travelling alongside the stamp on the channel.
    logic  pin_known;
    cal_t  pin_value;

    int unsigned stamps_sent = 0;
    int unsigned calendars_checked = 0;
    int unsigned mismatches = 0;

    // Idle rates in percent for the current phase, and the long hold-off request.
    int   sender_idle_pct = 16;
    int   receiver_stall_pct = 62;
    logic hold_off_request;

    always #5 clk = ~clk;

    // Day count since the epoch of a civil date (proleptic Gregorian).
    function automatic longint civil_day(longint yr, longint mon, longint dom);
        longint yy;
        longint era;
        longint yoe;
        longint shifted_mon;
        longint doe;
        yy = (mon <= 2) ? yr - 1 : yr;
        era = yy / 400;
        yoe = yy - era * 400;
        shifted_mon = (mon > 2) ? mon - 3 : mon + 9;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + (153 * shifted_mon + 2) / 5 + dom - 1;
        return era * ERA_DAYS + doe - MARCH_EPOCH;
    endfunction

    // Expected breakdown of one timestamp under the given hour offset.
    function automatic cal_t predict_calendar(logic [37:0] seconds, logic use_local,
                                              logic signed [4:0] hours);
        cal_t   c;
        bit     clipped;
        longint t;
        longint days;
        longint sod;
        longint z;
        longint era;
        longint doe;
        longint yoe;
        longint yr;
        longint doy;
        longint mp;
        longint mon;
        longint dom;
        clipped = (seconds > MAX_SECONDS);
        t = longint'(seconds);
        if (use_local)
            t += longint'(hours) * SECS_PER_HOUR;
        if (t < 0)
        begin
            t = 0;
            clipped = 1'b1;
        end
        else if (t > longint'(MAX_SECONDS))
        begin
            t = longint'(MAX_SECONDS);
            clipped = 1'b1;
        end
        days = t / SECS_PER_DAY;
        sod  = t % SECS_PER_DAY;
        // Civil date in 400-year eras whose years start in March.
        z   = days + MARCH_EPOCH;
        era = z / ERA_DAYS;
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr  = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        dom = doy - (153 * mp + 2) / 5 + 1;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        if (mon <= 2)
            yr++;
        c.years_since_1900 = 13'(yr - 1900);
        c.month_index      = 4'(mon - 1);
        c.day_of_month     = 5'(dom);
        c.day_of_year      = 9'(days - civil_day(yr, 1, 1));
        c.weekday_index    = 3'((days + 4) % 7);
        c.hour_of_day      = 5'(sod / SECS_PER_HOUR);
        c.minute_of_hour   = 6'((sod / SECS_PER_MIN) % 60);
        c.second_of_minute = 6'(sod % SECS_PER_MIN);
        c.out_of_range     = clipped;
        return c;
    endfunction

    function automatic void unpack_fields(cal_t c, output logic [15:0] f [9]);
        f[0] = 16'(c.years_since_1900);
        f[1] = 16'(c.month_index);
        f[2] = 16'(c.day_of_month);
        f[3] = 16'(c.day_of_year);
        f[4] = 16'(c.weekday_index);
        f[5] = 16'(c.hour_of_day);
        f[6] = 16'(c.minute_of_hour);
        f[7] = 16'(c.second_of_minute);
        f[8] = 16'(c.out_of_range);
    endfunction

    task automatic check_calendar(cal_t got, cal_t want);
        logic [15:0] g [9];
        logic [15:0] w [9];
        unpack_fields(got, g);
        unpack_fields(want, w);
        for (int i = 0; i < 9; i++)
        begin
            if (g[i] !== w[i])
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("calendar %0d: %s expected %0d, got %0d",
                             calendars_checked, field_name[i], w[i], g[i]);
            end
        end
    endtask

    // Random timestamp: mostly in range, with weight on the bounds, on values
    // above the bound, and on midnights around leap days and year ends.
    function automatic logic [37:0] pick_seconds();
        longint unsigned wide;
        longint unsigned span;
        longint          yr;
        longint          day;
        longint          sec;
        wide = {$urandom, $urandom};
        span = longint'(ALL_ONES) - longint'(MAX_SECONDS);
        case ($urandom_range(0, 9))
            0: return 38'($urandom_range(0, 200000));
            1: return MAX_SECONDS - 38'($urandom_range(0, 200000));
            2: return MAX_SECONDS + 38'd1 + 38'(wide % span);
            3, 4:
            begin
                // Century years exercise the divisible-by-100 and by-400 rules.
                yr = $urandom_range(0, 1) ? 100 * longint'($urandom_range(20, 99))
                                          : longint'($urandom_range(1971, 9999));
                if ($urandom_range(0, 1))
                    day = civil_day(yr, 3, 1) - longint'($urandom_range(0, 2));
                else
                    day = civil_day(yr, 1, 1) - longint'($urandom_range(0, 1));
                // Land within an offset's reach of midnight so the offset carries.
                sec = $urandom_range(0, 1) ? longint'($urandom_range(0, 57600))
                                           : SECS_PER_DAY - longint'($urandom_range(1, 57600));
                return 38'(day * SECS_PER_DAY + sec);
            end
            default: return 38'(wide % (longint'(MAX_SECONDS) + 1));
        endcase
    endfunction

    // Offer one stamp, idling at the phase's rate first; return at the transfer edge.
    task automatic offer_stamp(logic [37:0] seconds, logic use_local, bit pinned, cal_t want);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            stamp_if.valid <= 1'b0;
            @(posedge clk);
        end
        stamp_if.valid <= 1'b1;
        stamp_if.payload <= '{unix_seconds: seconds, use_local: use_local};
        pin_known <= pinned;
        pin_value <= want;
        do
            @(posedge clk);
        while (!stamp_if.ready);
        stamps_sent++;
    endtask

    // Drop the stamp valid and wait until every result is in and the pipe is empty.
    task automatic drain_pipeline();
        stamp_if.valid <= 1'b0;
        while (calendars_checked < stamps_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(logic signed [4:0] hours);
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= '{utc_offset_hours: hours};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Monitor: track register writes, predict each accepted stamp, check each
    // accepted calendar against the oldest expectation.
    always @(posedge clk)
    begin
        if (cfg_if.valid && cfg_if.ready)
            offset_model = cfg_if.payload.utc_offset_hours;
        if (stamp_if.valid && stamp_if.ready)
        begin
            if (pin_known)
                calendar_due.push_back(pin_value);
            else
                calendar_due.push_back(predict_calendar(stamp_if.payload.unix_seconds,
                                                        stamp_if.payload.use_local,
                                                        offset_model));
        end
        if (calendar_if.valid && calendar_if.ready)
        begin
            if (calendar_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("calendar %0d: transfer with no result expected",
                             calendars_checked);
            end
            else
                check_calendar(calendar_if.payload, calendar_due.pop_front());
            calendars_checked++;
        end
    end

    // Receiver: stall at the phase's rate; on request hold ready low once for a
    // long stretch so the pipeline fills and backs up into the stamp channel.
    initial
    begin : receiver
        bit hold_off_taken;
        hold_off_taken = 1'b0;
        calendar_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request && !hold_off_taken)
            begin
                hold_off_taken = 1'b1;
                calendar_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            calendar_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((stamp_if.valid && stamp_if.ready) || (cfg_if.valid && cfg_if.ready) ||
                (calendar_if.valid && calendar_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_unix_seconds_to_calendar_top NOT OK");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial
    begin : stimulus
        logic signed [4:0] phase_offset [RANDOM_PHASES];
        phase_offset = '{5'sd15, -5'sd15 - 5'sd1, 5'sd14, -5'sd12,
                         5'($urandom_range(0, 31)), 5'sd0};

        // Drive every input to a known value and hold reset.
        rst_n <= 1'b0;
        stamp_if.valid <= 1'b0;
        stamp_if.payload <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.payload <= '0;
        pin_known <= 1'b0;
        pin_value <= '0;
        hold_off_request <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; register writes only with the pipe empty.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_OFFSET)
            begin
                drain_pipeline();
                write_offset(5'(script[i].hours));
            end
            else
                offer_stamp(script[i].seconds, script[i].use_local,
                            script[i].pinned, script[i].want);
        end

        // Random phases: both sides idling, then the roles swapped, then full rate.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 2)
            begin
                sender_idle_pct = 16;
                receiver_stall_pct = 62;
            end
            else if (phase < 4)
            begin
                sender_idle_pct = 62;
                receiver_stall_pct = 16;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            drain_pipeline();
            write_offset(phase_offset[phase]);
            if (phase == 1)
                hold_off_request <= 1'b1;
            repeat (STAMPS_PER_PHASE)
                offer_stamp(pick_seconds(), ($urandom_range(0, 3) != 0), 1'b0, '0);
        end

        // Wait for the last results, then give the pipe time to show strays.
        drain_pipeline();
        if (mismatches == 0)
            $display("tb_unix_seconds_to_calendar_top OK");
        else
            $display("tb_unix_seconds_to_calendar_top NOT OK");
        $finish;
    end

endmodule
